### rtl/hdte_pkg.sv
`timescale 1ns / 1ps

package hdte_pkg;

    localparam logic [4:0] DATE_LEN = 5'd29;
    localparam logic [4:0] POS_SAT  = 5'd30;

    localparam logic [4:0] POS_DAY_END   = 5'd6;
    localparam logic [4:0] POS_YEAR_END  = 5'd15;
    localparam logic [4:0] POS_HOUR_END  = 5'd18;
    localparam logic [4:0] POS_MIN_END   = 5'd21;
    localparam logic [4:0] POS_MONTH_LO  = 5'd8;
    localparam logic [4:0] POS_MONTH_MID = 5'd9;
    localparam logic [4:0] POS_MONTH_HI  = 5'd10;

    localparam logic [13:0] YEAR_EPOCH = 14'd1970;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_LEN   = 2'd1,
        STAT_DIGIT = 2'd2,
        STAT_EARLY = 2'd3
    } t_status;

    typedef struct packed {
        logic        len_ok;
        logic        dig_err;
        logic [13:0] year;
        logic [3:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } t_date;

    localparam logic [23:0] MONTH_NAMES [12] = '{
        24'h6e614a, 24'h626546, 24'h72614d, 24'h727041, 24'h79614d, 24'h6e754a,
        24'h6c754a, 24'h677541, 24'h706553, 24'h74634f, 24'h766f4e, 24'h636544
    };

    function automatic logic [8:0] days_before(input logic leap, input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (idx >= 4'd2) && (idx <= 4'd11)) begin
            d = 9'(d + 9'd1);
        end
        return d;
    endfunction

endpackage

### rtl/http_date_to_epoch_seconds_core.sv
`timescale 1ns / 1ps

// RFC 1123 date string to Unix seconds.
// Input channel: one character per item on i_char_byte, i_last_char high on
// the final character. Each accepted item updates the field accumulators;
// only an item with i_last_char set produces a result.
// Output channel: o_epoch_seconds and o_status (0 ok, 1 bad length,
// 2 bad digit, 3 before epoch), one item per terminated string.
// Throughput: one input item per cycle while o_stall is low, including back-to-back strings.
// The edge that accepts the last character loads the first register of the
// epoch math's 7-register pipeline (field capture, products, quotients, day
// count, day-to-seconds multiply, sum, final check); o_valid marks the last.
// Receiver stall: the pipeline holds and fills its empty stages; o_stall
// rises only once the stage that captures finished strings is occupied and
// cannot advance. The parser is held along with it.
// Reset: clears the parser state and empties the pipeline.

module http_date_to_epoch_seconds_core import hdte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [37:0] o_epoch_seconds,
    output logic [1:0]  o_status
);

    logic  w_accept;
    logic  w_done;
    logic  w_ready;
    t_date w_date;

    assign o_stall  = !w_ready;
    assign w_accept = i_valid && w_ready;

    hdte_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_char_byte (i_char_byte),
        .i_last_char (i_last_char),
        .o_date      (w_date),
        .o_done      (w_done)
    );

    hdte_calc u_calc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (w_done),
        .i_date          (w_date),
        .o_in_ready      (w_ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_epoch_seconds (o_epoch_seconds),
        .o_status        (o_status)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_OK) |-> (o_epoch_seconds == 38'd0))
        else $error("error result carries nonzero seconds");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage is empty");

endmodule

### rtl/hdte_parse.sv
`timescale 1ns / 1ps

module hdte_parse import hdte_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_byte,
    input  logic       i_last_char,
    output t_date      o_date,
    output logic       o_done
);

    logic [4:0]  r_pos, n_pos;
    logic [6:0]  r_day, n_day;
    logic [15:0] r_mchars, n_mchars;
    logic [3:0]  r_month, n_month;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_hour, n_hour;
    logic [6:0]  r_min, n_min;
    logic [6:0]  r_sec, n_sec;
    logic        r_dig_err, n_dig_err;

    logic        w_is_digit;
    logic [3:0]  w_digit;
    logic        w_digit_pos;
    logic [23:0] w_key;

    always_comb begin
        w_is_digit  = (i_char_byte >= 8'h30) && (i_char_byte <= 8'h39);
        w_digit     = w_is_digit ? 4'(i_char_byte - 8'h30) : 4'd0;
        w_digit_pos = (r_pos == 5'd5) || (r_pos == 5'd6) ||
                      ((r_pos >= 5'd12) && (r_pos <= 5'd15)) ||
                      (r_pos == 5'd17) || (r_pos == 5'd18) ||
                      (r_pos == 5'd20) || (r_pos == 5'd21) ||
                      (r_pos == 5'd23) || (r_pos == 5'd24);
        w_key       = {i_char_byte, r_mchars};

        n_day     = r_day;
        n_mchars  = r_mchars;
        n_month   = r_month;
        n_year    = r_year;
        n_hour    = r_hour;
        n_min     = r_min;
        n_sec     = r_sec;
        n_dig_err = r_dig_err || (w_digit_pos && !w_is_digit);

        if (w_digit_pos && w_is_digit) begin
            if (r_pos <= POS_DAY_END) begin
                n_day = 7'(r_day * 7'd10 + {3'd0, w_digit});
            end else if (r_pos <= POS_YEAR_END) begin
                n_year = 14'(r_year * 14'd10 + {10'd0, w_digit});
            end else if (r_pos <= POS_HOUR_END) begin
                n_hour = 7'(r_hour * 7'd10 + {3'd0, w_digit});
            end else if (r_pos <= POS_MIN_END) begin
                n_min = 7'(r_min * 7'd10 + {3'd0, w_digit});
            end else begin
                n_sec = 7'(r_sec * 7'd10 + {3'd0, w_digit});
            end
        end

        if (r_pos == POS_MONTH_LO) begin
            n_mchars = {r_mchars[15:8], i_char_byte};
        end else if (r_pos == POS_MONTH_MID) begin
            n_mchars = {i_char_byte, r_mchars[7:0]};
        end else if (r_pos == POS_MONTH_HI) begin
            n_month = 4'd1;
            for (int i = 11; i >= 0; i--) begin
                if (w_key == MONTH_NAMES[i]) begin
                    n_month = 4'(i + 1);
                end
            end
        end

        n_pos = (r_pos < POS_SAT) ? 5'(r_pos + 5'd1) : r_pos;
    end

    assign o_done = i_accept && i_last_char;

    always_comb begin
        o_date.len_ok  = (r_pos == 5'(DATE_LEN - 5'd1));
        o_date.dig_err = n_dig_err;
        o_date.year    = n_year;
        o_date.month   = n_month;
        o_date.day     = n_day;
        o_date.hour    = n_hour;
        o_date.minute  = n_min;
        o_date.second  = n_sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_done) begin
            r_pos     <= 5'd0;
            r_day     <= 7'd0;
            r_mchars  <= 16'd0;
            r_month   <= 4'd1;
            r_year    <= 14'd0;
            r_hour    <= 7'd0;
            r_min     <= 7'd0;
            r_sec     <= 7'd0;
            r_dig_err <= 1'b0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_day     <= n_day;
            r_mchars  <= n_mchars;
            r_month   <= n_month;
            r_year    <= n_year;
            r_hour    <= n_hour;
            r_min     <= n_min;
            r_sec     <= n_sec;
            r_dig_err <= n_dig_err;
        end
    end

endmodule

### rtl/hdte_calc.sv
`timescale 1ns / 1ps

module hdte_calc import hdte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_date       i_date,
    output logic        o_in_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [37:0] o_epoch_seconds,
    output logic [1:0]  o_status
);

    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg;
    logic w_mv_a, w_mv_b, w_mv_c, w_mv_d, w_mv_e, w_mv_f, w_mv_g;

    assign w_mv_g = !r_vg || !i_stall;
    assign w_mv_f = !r_vf || w_mv_g;
    assign w_mv_e = !r_ve || w_mv_f;
    assign w_mv_d = !r_vd || w_mv_e;
    assign w_mv_c = !r_vc || w_mv_d;
    assign w_mv_b = !r_vb || w_mv_c;
    assign w_mv_a = !r_va || w_mv_b;
    assign o_in_ready = w_mv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
        end else begin
            if (w_mv_a) r_va <= i_in_valid;
            if (w_mv_b) r_vb <= r_va;
            if (w_mv_c) r_vc <= r_vb;
            if (w_mv_d) r_vd <= r_vc;
            if (w_mv_e) r_ve <= r_vd;
            if (w_mv_f) r_vf <= r_ve;
            if (w_mv_g) r_vg <= r_vf;
        end
    end

    // stage A: captured fields
    t_date r_a;

    always_ff @(posedge i_clk) begin
        if (w_mv_a) r_a <= i_date;
    end

    // stage B: products
    t_status     r_b_status, n_b_status;
    logic [13:0] r_b_year;
    logic [26:0] r_b_pq100, r_b_pq1, r_b_pq4;
    logic [22:0] r_b_yd365;
    logic [11:0] r_b_d4;
    logic [6:0]  r_b_day, r_b_sec;
    logic [3:0]  r_b_month;
    logic [18:0] r_b_h3600;
    logic [12:0] r_b_m60;
    logic [13:0] w_y1, w_y4, w_y69, w_y70;

    always_comb begin
        w_y1  = 14'(r_a.year - 14'd1901);
        w_y4  = 14'(r_a.year - 14'd1601);
        w_y69 = 14'(r_a.year - 14'd1969);
        w_y70 = 14'(r_a.year - YEAR_EPOCH);
        if (!r_a.len_ok) begin
            n_b_status = STAT_LEN;
        end else if (r_a.dig_err) begin
            n_b_status = STAT_DIGIT;
        end else if (r_a.year < YEAR_EPOCH) begin
            n_b_status = STAT_EARLY;
        end else begin
            n_b_status = STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv_b) begin
            r_b_status <= n_b_status;
            r_b_year   <= r_a.year;
            r_b_pq100  <= {13'd0, r_a.year} * 27'd5243;
            r_b_pq1    <= {13'd0, w_y1} * 27'd5243;
            r_b_pq4    <= {13'd0, w_y4} * 27'd5243;
            r_b_yd365  <= {9'd0, w_y70} * 23'd365;
            r_b_d4     <= w_y69[13:2];
            r_b_day    <= r_a.day;
            r_b_month  <= r_a.month;
            r_b_sec    <= r_a.second;
            r_b_h3600  <= {12'd0, r_a.hour} * 19'd3600;
            r_b_m60    <= {6'd0, r_a.minute} * 13'd60;
        end
    end

    // stage C: quotients, leap year, day of year, time of day
    t_status     r_c_status;
    logic [8:0]  r_c_yday;
    logic [7:0]  r_c_q1;
    logic [5:0]  r_c_q4;
    logic [22:0] r_c_yd365;
    logic [11:0] r_c_d4;
    logic [18:0] r_c_tod;
    logic [7:0]  w_q100;
    logic        w_leap;

    always_comb begin
        w_q100 = r_b_pq100[26:19];
        w_leap = (r_b_year[1:0] == 2'd0) &&
                 ((14'({6'd0, w_q100} * 14'd100) != r_b_year) || (w_q100[1:0] == 2'd0));
    end

    always_ff @(posedge i_clk) begin
        if (w_mv_c) begin
            r_c_status <= r_b_status;
            r_c_yday   <= {2'd0, r_b_day} + days_before(w_leap, 4'(r_b_month - 4'd1));
            r_c_q1     <= r_b_pq1[26:19];
            r_c_q4     <= r_b_pq4[26:21];
            r_c_yd365  <= r_b_yd365;
            r_c_d4     <= r_b_d4;
            r_c_tod    <= {12'd0, r_b_sec} + r_b_h3600 + {6'd0, r_b_m60};
        end
    end

    // stage D: day count
    t_status     r_d_status;
    logic [22:0] r_d_days;
    logic [18:0] r_d_tod;

    always_ff @(posedge i_clk) begin
        if (w_mv_d) begin
            r_d_status <= r_c_status;
            r_d_days   <= r_c_yd365 + {14'd0, r_c_yday} + {11'd0, r_c_d4} -
                          {15'd0, r_c_q1} + {17'd0, r_c_q4};
            r_d_tod    <= r_c_tod;
        end
    end

    // stage E: days to seconds
    t_status     r_e_status;
    logic [38:0] r_e_prod;
    logic [18:0] r_e_tod;

    always_ff @(posedge i_clk) begin
        if (w_mv_e) begin
            r_e_status <= r_d_status;
            r_e_prod   <= {16'd0, r_d_days} * 39'd86400;
            r_e_tod    <= r_d_tod;
        end
    end

    // stage F: total seconds, day counted from one
    t_status     r_f_status;
    logic [38:0] r_f_total;

    always_ff @(posedge i_clk) begin
        if (w_mv_f) begin
            r_f_status <= r_e_status;
            r_f_total  <= r_e_prod + {20'd0, r_e_tod};
        end
    end

    // stage G: result register
    t_status     r_g_status, n_g_status;
    logic [37:0] r_g_secs, n_g_secs;
    logic [38:0] w_less_day;

    always_comb begin
        w_less_day = r_f_total - 39'd86400;
        if (r_f_status != STAT_OK) begin
            n_g_status = r_f_status;
            n_g_secs   = 38'd0;
        end else if (r_f_total < 39'd86400) begin
            n_g_status = STAT_EARLY;
            n_g_secs   = 38'd0;
        end else begin
            n_g_status = STAT_OK;
            n_g_secs   = w_less_day[37:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv_g) begin
            r_g_status <= n_g_status;
            r_g_secs   <= n_g_secs;
        end
    end

    assign o_valid         = r_vg;
    assign o_epoch_seconds = r_g_secs;
    assign o_status        = r_g_status;

endmodule
